/* hdl/strip_chart_graph_renderer_core_macros.svh */
// assertion macros for the strip chart renderer checker
// expects signals named clk and rst in the scope of each use
`ifndef STRIP_CHART_GRAPH_RENDERER_CORE_MACROS_SVH
`define STRIP_CHART_GRAPH_RENDERER_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SCGR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scgr implication check failed");

// condition holds at every edge out of reset
`define SCGR_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("scgr invariant check failed");

`endif

/* hdl/scgr_pkg.sv */
// types and constants of the strip chart renderer
// no dependencies; used by the core and its checker
`default_nettype none

package scgr_pkg;

  typedef struct packed {
    logic        mode;
    logic [6:0]  cpu_load;
    logic [7:0]  cpu_clock;
    logic [31:0] free_ram;
    logic [7:0]  column;
    logic [6:0]  row;
  } cmd_t;

  typedef struct packed {
    logic [15:0] pixel_color;
    logic        drawn;
    logic        history_full;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_LDIV,
    ST_MDIV,
    ST_RDIV,
    ST_WRITE
  } state_t;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  localparam logic [1:0] STYLE_OFF    = 2'd0;
  localparam logic [1:0] STYLE_LINE   = 2'd1;
  localparam logic [1:0] STYLE_FILLED = 2'd2;

  localparam logic [2:0] REG_WIDTH       = 3'd0;
  localparam logic [2:0] REG_HEIGHT      = 3'd1;
  localparam logic [2:0] REG_STYLES      = 3'd2;
  localparam logic [2:0] REG_DIVIDER     = 3'd3;
  localparam logic [2:0] REG_COLOR_SLOW  = 3'd4;
  localparam logic [2:0] REG_COLOR_MID   = 3'd5;
  localparam logic [2:0] REG_COLOR_FAST  = 3'd6;
  localparam logic [2:0] REG_COLOR_RAM   = 3'd7;

  localparam int WIDTH_FLOOR  = 30;
  localparam int HEIGHT_FLOOR = 10;

  localparam logic [8:0] WIDTH_RST   = 9'd30;
  localparam logic [7:0] HEIGHT_RST  = 8'd10;
  localparam logic [7:0] DIVIDER_RST = 8'd1;

  localparam logic [15:0] BACKGROUND     = 16'hE000;
  localparam logic [15:0] UNKNOWN_CLOCK  = 16'hFFFF;
  localparam logic [6:0]  LOAD_FULL      = 7'd100;
  localparam logic [7:0]  CLK_SLOW_A     = 8'd26;
  localparam logic [7:0]  CLK_SLOW_B     = 8'd52;
  localparam logic [7:0]  CLK_MID        = 8'd104;
  localparam logic [7:0]  CLK_FAST       = 8'd208;

  // x / 100 as (x * 5243) >> 19, exact for x below 43690
  localparam logic [12:0] LOAD_RECIP = 13'd5243;
  localparam int          LOAD_SHIFT = 19;

  // serial divider: 40-bit dividend (32-bit sample times 8-bit height)
  localparam int DIV_NUM_W = 40;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_CNT_W = 6;

endpackage

`default_nettype wire

/* hdl/strip_chart_graph_renderer_core.sv */
// strip chart renderer core: ring memory of chart levels and a pixel query pipe; uses scgr_pkg
// query items: strobe via q1_valid then result_valid; one query accepted per cycle while idle
// sample items: busy through the write state; load scaling by one reciprocal multiply,
//   then up to two serial divides (divider phase, ram scaling)
// reset: registers to defaults, then busy for a pass that zeroes the ring
// the receiver cannot stall results
`default_nettype none

module strip_chart_graph_renderer_core #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 128
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire scgr_pkg::cmd_t    cmd,
  output logic                   result_valid,
  output scgr_pkg::result_t      result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int AW = $clog2(MAX_COLUMNS);
  localparam int WW = $clog2(MAX_COLUMNS + 1);
  localparam int SW = $clog2(MAX_COLUMNS + 256);
  localparam int NW = scgr_pkg::DIV_NUM_W;
  localparam int DW = scgr_pkg::DIV_DEN_W;
  localparam int CW = scgr_pkg::DIV_CNT_W;

  // configuration registers
  logic [8:0]  graph_width;
  logic [7:0]  graph_height;
  logic [3:0]  trace_styles;
  logic [7:0]  ram_divider;
  logic [15:0] color_slow;
  logic [15:0] color_mid;
  logic [15:0] color_fast;
  logic [15:0] color_ram;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      graph_width  <= scgr_pkg::WIDTH_RST;
      graph_height <= scgr_pkg::HEIGHT_RST;
      trace_styles <= 4'd0;
      ram_divider  <= scgr_pkg::DIVIDER_RST;
      color_slow   <= 16'd0;
      color_mid    <= 16'd0;
      color_fast   <= 16'd0;
      color_ram    <= 16'd0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        scgr_pkg::REG_WIDTH:      graph_width  <= pwdata[8:0];
        scgr_pkg::REG_HEIGHT:     graph_height <= pwdata[7:0];
        scgr_pkg::REG_STYLES:     trace_styles <= pwdata[3:0];
        scgr_pkg::REG_DIVIDER:    ram_divider  <= pwdata[7:0];
        scgr_pkg::REG_COLOR_SLOW: color_slow   <= pwdata[15:0];
        scgr_pkg::REG_COLOR_MID:  color_mid    <= pwdata[15:0];
        scgr_pkg::REG_COLOR_FAST: color_fast   <= pwdata[15:0];
        scgr_pkg::REG_COLOR_RAM:  color_ram    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      scgr_pkg::REG_WIDTH:      prdata = 32'(graph_width);
      scgr_pkg::REG_HEIGHT:     prdata = 32'(graph_height);
      scgr_pkg::REG_STYLES:     prdata = 32'(trace_styles);
      scgr_pkg::REG_DIVIDER:    prdata = 32'(ram_divider);
      scgr_pkg::REG_COLOR_SLOW: prdata = 32'(color_slow);
      scgr_pkg::REG_COLOR_MID:  prdata = 32'(color_mid);
      scgr_pkg::REG_COLOR_FAST: prdata = 32'(color_fast);
      scgr_pkg::REG_COLOR_RAM:  prdata = 32'(color_ram);
      default:                  prdata = 32'd0;
    endcase
  end

  // effective geometry
  logic [WW-1:0] width_eff;
  logic [7:0]    height_eff;
  logic [1:0]    load_style;
  logic [1:0]    ram_style;
  logic [7:0]    div_eff;

  always_comb begin
    if (graph_width < 9'(scgr_pkg::WIDTH_FLOOR)) begin
      width_eff = WW'(scgr_pkg::WIDTH_FLOOR);
    end else if (32'(graph_width) > MAX_COLUMNS) begin
      width_eff = WW'(MAX_COLUMNS);
    end else begin
      width_eff = WW'(graph_width);
    end
    if (graph_height < 8'(scgr_pkg::HEIGHT_FLOOR)) begin
      height_eff = 8'(scgr_pkg::HEIGHT_FLOOR);
    end else if (graph_height > 8'(MAX_ROWS)) begin
      height_eff = 8'(MAX_ROWS);
    end else begin
      height_eff = graph_height;
    end
  end

  assign load_style = trace_styles[1:0];
  assign ram_style  = trace_styles[3:2];
  assign div_eff    = (ram_divider == 8'd0) ? 8'd1 : ram_divider;

  // control and chart state
  scgr_pkg::state_t state, state_next;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] wpos;
  logic          wrapped;
  logic [31:0]   peak;
  logic [7:0]    ram_last;
  logic [7:0]    lvl_load;
  logic [7:0]    s_clock;
  logic [31:0]   s_ram;
  logic [14:0]   s_lprod;

  logic accept, q_acc, s_acc;
  assign accept = start & ~busy;
  assign q_acc  = accept & (cmd.mode == scgr_pkg::MODE_QUERY);
  assign s_acc  = accept & (cmd.mode == scgr_pkg::MODE_SAMPLE);

  // serial restoring divider
  logic [NW-1:0] dnum;
  logic [DW-1:0] dden;
  logic [DW-1:0] drem;
  logic [7:0]    dquo;
  logic [CW-1:0] dcnt;
  logic          div_done;
  logic [DW:0]   div_sh;
  logic          div_ge;
  logic [DW:0]   div_diff;
  logic          div_load;
  logic [NW-1:0] div_num_in;
  logic [DW-1:0] div_den_in;
  logic [6:0]    ld_sat;
  logic [14:0]   lprod;
  logic [27:0]   lrecip;
  logic [NW-1:0] rprod;
  logic [31:0]   peak_max;

  assign div_done = (dcnt == '0);
  assign div_sh   = {drem, dnum[NW-1]};
  assign div_ge   = (div_sh >= {1'b0, dden});
  assign div_diff = div_sh - {1'b0, dden};

  assign ld_sat   = (cmd.cpu_load > scgr_pkg::LOAD_FULL) ? scgr_pkg::LOAD_FULL : cmd.cpu_load;
  assign lprod    = 15'(height_eff) * 15'(ld_sat);
  assign lrecip   = 28'(s_lprod) * 28'(scgr_pkg::LOAD_RECIP);
  assign rprod    = NW'(s_ram) * NW'(height_eff);
  assign peak_max = (s_ram > peak) ? s_ram : peak;

  assign div_load = (state_next != state) &&
                    ((state_next == scgr_pkg::ST_MDIV) ||
                     (state_next == scgr_pkg::ST_RDIV));

  always_comb begin
    case (state_next)
      scgr_pkg::ST_MDIV: begin
        div_num_in = NW'(wpos);
        div_den_in = DW'(div_eff);
      end
      default: begin
        div_num_in = rprod;
        div_den_in = peak_max;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (div_load) begin
      dcnt <= CW'(NW);
    end else if (!div_done) begin
      dcnt <= dcnt - CW'(1);
    end
  end

  // quotient keeps its low byte only; every result here fits a byte
  always_ff @(posedge clk) begin
    if (div_load) begin
      dnum <= div_num_in;
      dden <= div_den_in;
      drem <= '0;
      dquo <= '0;
    end else if (!div_done) begin
      dnum <= {dnum[NW-2:0], 1'b0};
      drem <= div_ge ? div_diff[DW-1:0] : div_sh[DW-1:0];
      dquo <= {dquo[6:0], div_ge};
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      scgr_pkg::ST_IDLE: begin
        if (s_acc) begin
          if (load_style != scgr_pkg::STYLE_OFF) begin
            state_next = scgr_pkg::ST_LDIV;
          end else if (ram_style != scgr_pkg::STYLE_OFF) begin
            state_next = scgr_pkg::ST_MDIV;
          end else begin
            state_next = scgr_pkg::ST_WRITE;
          end
        end
      end
      scgr_pkg::ST_CLEAR: begin
        if (clr_addr == AW'(MAX_COLUMNS - 1)) begin
          state_next = scgr_pkg::ST_IDLE;
        end
      end
      scgr_pkg::ST_LDIV: begin
        state_next = (ram_style != scgr_pkg::STYLE_OFF) ? scgr_pkg::ST_MDIV
                                                        : scgr_pkg::ST_WRITE;
      end
      scgr_pkg::ST_MDIV: begin
        if (div_done) begin
          if (drem == '0 && peak_max != 32'd0) begin
            state_next = scgr_pkg::ST_RDIV;
          end else begin
            state_next = scgr_pkg::ST_WRITE;
          end
        end
      end
      scgr_pkg::ST_RDIV: begin
        if (div_done) begin
          state_next = scgr_pkg::ST_WRITE;
        end
      end
      scgr_pkg::ST_WRITE: state_next = scgr_pkg::ST_IDLE;
      default:            state_next = scgr_pkg::ST_IDLE;
    endcase
  end

  // fsm outputs
  logic          we_load;
  logic          we_ram;
  logic [AW-1:0] waddr;
  logic [7:0]    wload;
  logic [7:0]    wclk;
  logic [7:0]    wram;

  always_comb begin
    busy    = 1'b1;
    we_load = 1'b0;
    we_ram  = 1'b0;
    waddr   = wpos;
    wload   = lvl_load;
    wclk    = s_clock;
    wram    = ram_last;
    case (state)
      scgr_pkg::ST_IDLE: busy = 1'b0;
      scgr_pkg::ST_CLEAR: begin
        we_load = 1'b1;
        we_ram  = 1'b1;
        waddr   = clr_addr;
        wload   = 8'd0;
        wclk    = 8'd0;
        wram    = 8'd0;
      end
      scgr_pkg::ST_WRITE: begin
        we_load = (load_style != scgr_pkg::STYLE_OFF);
        we_ram  = (ram_style != scgr_pkg::STYLE_OFF);
      end
      default: ;
    endcase
  end

  logic [AW:0] pos_inc;
  assign pos_inc = (AW+1)'(wpos) + (AW+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= scgr_pkg::ST_CLEAR;
      clr_addr <= '0;
      wpos     <= '0;
      wrapped  <= 1'b0;
      peak     <= 32'd0;
      ram_last <= 8'd0;
    end else begin
      state <= state_next;
      if (state == scgr_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == scgr_pkg::ST_MDIV && div_done && drem == '0) begin
        peak <= peak_max;
        if (peak_max == 32'd0) begin
          ram_last <= 8'd0;
        end
      end
      if (state == scgr_pkg::ST_RDIV && div_done) begin
        ram_last <= dquo;
      end
      if (state == scgr_pkg::ST_WRITE) begin
        if (pos_inc >= (AW+1)'(width_eff)) begin
          wpos    <= '0;
          wrapped <= 1'b1;
        end else begin
          wpos <= AW'(pos_inc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      s_clock <= cmd.cpu_clock;
      s_ram   <= cmd.free_ram;
      s_lprod <= lprod;
    end
    // height * load / 100 by reciprocal multiply
    if (state == scgr_pkg::ST_LDIV) begin
      lvl_load <= lrecip[scgr_pkg::LOAD_SHIFT +: 8];
    end
  end

  // query address: (wpos + column) mod width by conditional subtracts
  logic [SW-1:0]   qsum;
  logic [2*SW-1:0] wshift;
  logic [AW-1:0]   qaddr;

  always_comb begin
    qsum   = SW'(wpos) + SW'(cmd.column);
    wshift = '0;
    for (int k = SW - 5; k >= 0; k--) begin
      wshift = (2*SW)'(width_eff) << k;
      if ((2*SW)'(qsum) >= wshift) begin
        qsum = qsum - SW'(wshift);
      end
    end
  end

  assign qaddr = AW'(qsum);

  // ring memory: [23:16] ram level, [15:8] clock value, [7:0] load level
  logic [23:0] mem [MAX_COLUMNS];
  logic [23:0] rd_data;

  always_ff @(posedge clk) begin
    if (we_load) begin
      mem[waddr][15:0] <= {wclk, wload};
    end
    if (we_ram) begin
      mem[waddr][23:16] <= wram;
    end
    rd_data <= mem[qaddr];
  end

  // query pipe
  logic       q1_valid;
  logic [6:0] q1_row;
  logic       q1_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      q1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      q1_valid     <= q_acc;
      result_valid <= q1_valid;
    end
  end

  always_ff @(posedge clk) begin
    q1_row  <= cmd.row;
    q1_full <= wrapped;
  end

  // pixel color, lower trace first
  logic [7:0]        lv, rv, cv, yq, y1, y2;
  logic [15:0]       lc, c1, c2, pix;
  logic [1:0]        t1, t2;
  logic              drawn;
  scgr_pkg::result_t res_next;

  assign lv = rd_data[7:0];
  assign cv = rd_data[15:8];
  assign rv = rd_data[23:16];
  assign yq = {1'b0, q1_row};

  always_comb begin
    case (cv)
      scgr_pkg::CLK_SLOW_A: lc = color_slow;
      scgr_pkg::CLK_SLOW_B: lc = color_slow;
      scgr_pkg::CLK_MID:    lc = color_mid;
      scgr_pkg::CLK_FAST:   lc = color_fast;
      default:              lc = scgr_pkg::UNKNOWN_CLOCK;
    endcase
  end

  always_comb begin
    y1    = 8'd0;
    y2    = 8'd0;
    c1    = 16'd0;
    c2    = 16'd0;
    t1    = scgr_pkg::STYLE_OFF;
    t2    = scgr_pkg::STYLE_OFF;
    drawn = 1'b1;
    if (load_style != scgr_pkg::STYLE_OFF && ram_style != scgr_pkg::STYLE_OFF) begin
      if (lv < rv) begin
        y1 = lv; c1 = lc;        t1 = load_style;
        y2 = rv; c2 = color_ram; t2 = ram_style;
      end else begin
        y2 = lv; c2 = lc;        t2 = load_style;
        y1 = rv; c1 = color_ram; t1 = ram_style;
      end
    end else if (load_style != scgr_pkg::STYLE_OFF) begin
      y1 = lv; c1 = lc; t1 = load_style;
    end else if (ram_style != scgr_pkg::STYLE_OFF) begin
      y1 = rv; c1 = color_ram; t1 = ram_style;
    end else begin
      drawn = 1'b0;
    end

    if (!drawn) begin
      pix = 16'd0;
    end else if (yq < y1) begin
      if (t1 == scgr_pkg::STYLE_FILLED) begin
        pix = c1;
      end else if (t2 == scgr_pkg::STYLE_FILLED) begin
        pix = c2;
      end else begin
        pix = scgr_pkg::BACKGROUND;
      end
    end else if (yq == y1) begin
      if (t1 != scgr_pkg::STYLE_OFF) begin
        pix = c1;
      end else if (t2 == scgr_pkg::STYLE_FILLED) begin
        pix = c2;
      end else begin
        pix = scgr_pkg::BACKGROUND;
      end
    end else if (yq < y2 && t2 != scgr_pkg::STYLE_OFF) begin
      pix = (t2 == scgr_pkg::STYLE_FILLED) ? c2 : scgr_pkg::BACKGROUND;
    end else if (yq == y2 && t2 != scgr_pkg::STYLE_OFF) begin
      pix = c2;
    end else begin
      pix = scgr_pkg::BACKGROUND;
    end

    res_next.pixel_color  = pix;
    res_next.drawn        = drawn;
    res_next.history_full = q1_full;
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

endmodule

`default_nettype wire

/* hdl/scgr_checker.sv */
// port-level checks of the strip chart renderer, bound to the core
// depends on scgr_pkg and strip_chart_graph_renderer_core_macros.svh
`default_nettype none
`include "strip_chart_graph_renderer_core_macros.svh"

module scgr_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire scgr_pkg::cmd_t    cmd,
  input wire logic              result_valid,
  input wire scgr_pkg::result_t result,
  input wire logic              pready
);

  // every result answers a query that the core accepted earlier
  `SCGR_ASSERT_IMPL(a_result_after_query, result_valid, $past(start && !busy && cmd.mode == scgr_pkg::MODE_QUERY, 2))

  // busy only goes high because a sample item was taken
  `SCGR_ASSERT_IMPL(a_busy_from_sample, $rose(busy), $past(start && cmd.mode == scgr_pkg::MODE_SAMPLE))

  // an undrawn pixel reports color zero
  `SCGR_ASSERT_IMPL(a_undrawn_zero, result_valid && !result.drawn, result.pixel_color == 16'h0000)

  `SCGR_ASSERT_ALWAYS(a_pready_high, pready)

endmodule

bind strip_chart_graph_renderer_core scgr_checker u_scgr_checker (.*);

`default_nettype wire
